@@ src/fcull_pkg.sv @@
// Shared types, constants and helpers for the frustum plane culler.
// Used by fcull_cell, fcull_eval and frustum_plane_cull; depends on nothing.
package fcull_pkg;

   localparam int NumPlanes = 6;
   localparam int WordW     = 32;
   localparam int CompW     = 33;
   localparam int HalfW     = 31;
   localparam int ProdW     = 66;
   localparam int AccW      = 136;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SPHERE = 2'd1;
   localparam logic [1:0] OP_BOX    = 2'd2;

   localparam logic [1:0] COL_X = 2'd0;
   localparam logic [1:0] COL_Y = 2'd1;
   localparam logic [1:0] COL_Z = 2'd2;
   localparam logic [1:0] COL_D = 2'd3;

   typedef struct packed {
      logic signed [CompW-1:0] d;
      logic signed [CompW-1:0] n2;
      logic signed [CompW-1:0] n1;
      logic signed [CompW-1:0] n0;
   } plane_type;

   typedef struct packed {
      logic                    is_box;
      logic                    norm;
      logic signed [WordW-1:0] cx;
      logic signed [WordW-1:0] cy;
      logic signed [WordW-1:0] cz;
      logic signed [WordW-1:0] rad;
      logic [HalfW-1:0]        hx;
      logic [HalfW-1:0]        hy;
      logic [HalfW-1:0]        hz;
   } test_req_type;

   typedef struct packed {
      logic busy;
      logic advance;
      logic done;
      logic in_view;
   } eval_stat_type;

   function automatic logic [CompW-1:0] mag_comp(input logic [CompW-1:0] v);
      mag_comp = v[CompW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [WordW-1:0] mag_word(input logic [WordW-1:0] v);
      mag_word = v[WordW-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

@@ src/frustum_plane_cull.sv @@
// Top level of the six-plane frustum culler: plane cell ring, evaluator, config.
// Depends on fcull_pkg, fcull_cell and fcull_eval.
//
// A load transaction (start with operation 0) raises no busy. A sphere or box
// test holds busy while a single shared 33x33 multiplier and 136-bit
// accumulator visit the six planes one at a time as the ring of plane cells
// rotates: each plane runs a sequence of multiply steps, each a multiply state
// then an accumulate state, and then a decide state. The sequence is longest
// for a sphere with normalization on and shortest with normalization off.
// The result is on rsp_inside_res, marked by a one-cycle rsp_valid strobe,
// in the cycle busy falls; it cannot be held off, so sample it then.
// Operation code 3 is accepted and dropped.
module frustum_plane_cull (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic [1:0]                           req_column_index,
   input  logic signed [fcull_pkg::WordW-1:0]   req_word_0,
   input  logic signed [fcull_pkg::WordW-1:0]   req_word_1,
   input  logic signed [fcull_pkg::WordW-1:0]   req_word_2,
   input  logic signed [fcull_pkg::WordW-1:0]   req_word_3,
   input  logic [fcull_pkg::HalfW-1:0]          req_half_x,
   input  logic [fcull_pkg::HalfW-1:0]          req_half_y,
   input  logic [fcull_pkg::HalfW-1:0]          req_half_z,
   output logic                                 rsp_valid,
   output logic                                 rsp_inside_res,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data
);

   localparam int NumPlanes = fcull_pkg::NumPlanes;
   localparam int CompW     = fcull_pkg::CompW;

   logic                        norm_ff;
   logic                        accept;
   logic                        load_en;
   logic                        start_test;
   fcull_pkg::test_req_type     req;
   fcull_pkg::eval_stat_type    stat;
   fcull_pkg::plane_type        plane_q [NumPlanes];
   logic signed [CompW-1:0]     load_val [NumPlanes];
   logic signed [CompW-1:0]     w3x;
   logic signed [CompW-1:0]     wx [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff <= 1'b1;
      end else if (csr_wr_en) begin
         norm_ff <= csr_wr_data;
      end
   end

   assign accept     = start && !stat.busy;
   assign load_en    = accept && (req_operation == fcull_pkg::OP_LOAD);
   assign start_test = accept && (req_operation == fcull_pkg::OP_SPHERE ||
                                  req_operation == fcull_pkg::OP_BOX);

   assign w3x   = CompW'(req_word_3);
   assign wx[0] = CompW'(req_word_0);
   assign wx[1] = CompW'(req_word_1);
   assign wx[2] = CompW'(req_word_2);

   assign req.is_box = (req_operation == fcull_pkg::OP_BOX);
   assign req.norm   = norm_ff;
   assign req.cx     = req_word_0;
   assign req.cy     = req_word_1;
   assign req.cz     = req_word_2;
   assign req.rad    = req_word_3;
   assign req.hx     = req_half_x;
   assign req.hy     = req_half_y;
   assign req.hz     = req_half_z;

   for (genvar a = 0; a < 3; a++) begin : g_load
      assign load_val[2*a]     = w3x + wx[a];
      assign load_val[2*a + 1] = w3x - wx[a];
   end

   for (genvar k = 0; k < NumPlanes; k++) begin : g_ring
      fcull_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load_en   (load_en),
         .load_sel  (req_column_index),
         .load_val  (load_val[k]),
         .shift_en  (stat.advance),
         .nbr_in    (plane_q[(k + 1) % NumPlanes]),
         .plane_out (plane_q[k])
      );
   end

   fcull_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .start_test (start_test),
      .req        (req),
      .plane      (plane_q[0]),
      .stat       (stat)
   );

   assign busy           = stat.busy;
   assign rsp_valid      = stat.done;
   assign rsp_inside_res = stat.in_view;

   a_valid_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      start_test |=> busy)
      else $error("accepted test did not raise busy");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (load_en && !busy) |=> !rsp_valid)
      else $error("load produced a result");

endmodule

@@ src/fcull_cell.sv @@
// One plane cell of the rotating plane ring: holds four signed Q17.16 components.
// Depends on fcull_pkg.
module fcull_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load_en,
   input  logic [1:0]                     load_sel,
   input  logic signed [fcull_pkg::CompW-1:0] load_val,
   input  logic                           shift_en,
   input  fcull_pkg::plane_type           nbr_in,
   output fcull_pkg::plane_type           plane_out
);

   fcull_pkg::plane_type plane_ff;
   fcull_pkg::plane_type plane_in;

   always_comb begin
      plane_in = plane_ff;
      if (shift_en) begin
         plane_in = nbr_in;
      end else if (load_en) begin
         case (load_sel)
            fcull_pkg::COL_X: plane_in.n0 = load_val;
            fcull_pkg::COL_Y: plane_in.n1 = load_val;
            fcull_pkg::COL_Z: plane_in.n2 = load_val;
            fcull_pkg::COL_D: plane_in.d  = load_val;
            default:          plane_in    = plane_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   assign plane_out = plane_ff;

endmodule

@@ src/fcull_eval.sv @@
// Plane evaluator: one 33x33 multiplier and a wide accumulator stepping through
// the plane at the head of the cell ring. Depends on fcull_pkg.
module fcull_eval (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_test,
   input  fcull_pkg::test_req_type       req,
   input  fcull_pkg::plane_type          plane,
   output fcull_pkg::eval_stat_type      stat
);

   localparam int AccW  = fcull_pkg::AccW;
   localparam int ProdW = fcull_pkg::ProdW;
   localparam int CompW = fcull_pkg::CompW;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_ACC    = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   localparam logic [2:0] SH0  = 3'd0;
   localparam logic [2:0] SH16 = 3'd1;
   localparam logic [2:0] SH33 = 3'd2;
   localparam logic [2:0] SH34 = 3'd3;
   localparam logic [2:0] SH66 = 3'd4;

   localparam logic [2:0] LastPlane = 3'(fcull_pkg::NumPlanes - 1);

   logic [1:0]               state_ff;
   logic [3:0]               step_ff;
   logic [2:0]               plane_ff;
   logic                     inside_ff;
   logic                     done_ff;
   logic                     result_ff;
   fcull_pkg::test_req_type  req_ff;
   logic [ProdW-1:0]         prod_ff;
   logic                     pneg_ff;
   logic [2:0]               psh_ff;
   logic [ProdW-1:0]         smag_ff;
   logic                     sneg_ff;
   logic [ProdW-1:0]         nn_ff;
   logic [62:0]              r2_ff;
   logic [AccW-1:0]          acc_ff;

   logic [CompW-1:0] opa;
   logic [CompW-1:0] opb;
   logic             oneg;
   logic [2:0]       osh;
   logic [CompW-1:0] n0m, n1m, n2m, cxm, cym, czm, rm;
   logic [CompW-1:0] r2lo, r2hi;
   logic [3:0]       last_step;
   logic [AccW-1:0]  prod_ext;
   logic [AccW-1:0]  shifted;
   logic [AccW-1:0]  term;
   logic [AccW-1:0]  dext;
   logic [AccW-1:0]  acc_abs;
   logic [AccW-1:0]  acc_in;
   logic             acc_neg;
   logic             acc_zero;
   logic             outside;

   assign n0m  = fcull_pkg::mag_comp(plane.n0);
   assign n1m  = fcull_pkg::mag_comp(plane.n1);
   assign n2m  = fcull_pkg::mag_comp(plane.n2);
   assign cxm  = {1'b0, fcull_pkg::mag_word(req_ff.cx)};
   assign cym  = {1'b0, fcull_pkg::mag_word(req_ff.cy)};
   assign czm  = {1'b0, fcull_pkg::mag_word(req_ff.cz)};
   assign rm   = {1'b0, fcull_pkg::mag_word(req_ff.rad)};
   assign r2lo = r2_ff[32:0];
   assign r2hi = {3'b000, r2_ff[62:33]};

   assign last_step = req_ff.is_box ? 4'd5 : (req_ff.norm ? 4'd13 : 4'd3);

   always_comb begin
      opa  = '0;
      opb  = '0;
      oneg = 1'b0;
      osh  = SH0;
      case (step_ff)
         4'd0: begin
            opa = n0m; opb = cxm; oneg = plane.n0[CompW-1] ^ req_ff.cx[31];
         end
         4'd1: begin
            opa = n1m; opb = cym; oneg = plane.n1[CompW-1] ^ req_ff.cy[31];
         end
         4'd2: begin
            opa = n2m; opb = czm; oneg = plane.n2[CompW-1] ^ req_ff.cz[31];
         end
         4'd3: begin
            if (req_ff.is_box) begin
               opa = n0m; opb = {2'b00, req_ff.hx};
            end else if (req_ff.norm) begin
               opa = n0m; opb = n0m;
            end else begin
               opa = rm; opb = 33'd1; oneg = req_ff.rad[31]; osh = SH16;
            end
         end
         4'd4: begin
            opa = n1m;
            opb = req_ff.is_box ? {2'b00, req_ff.hy} : n1m;
         end
         4'd5: begin
            opa = n2m;
            opb = req_ff.is_box ? {2'b00, req_ff.hz} : n2m;
         end
         4'd6: begin
            opa = rm; opb = rm;
         end
         4'd7: begin
            opa = r2lo; opb = nn_ff[32:0]; oneg = 1'b1;
         end
         4'd8: begin
            opa = r2lo; opb = nn_ff[65:33]; oneg = 1'b1; osh = SH33;
         end
         4'd9: begin
            opa = r2hi; opb = nn_ff[32:0]; oneg = 1'b1; osh = SH33;
         end
         4'd10: begin
            opa = r2hi; opb = nn_ff[65:33]; oneg = 1'b1; osh = SH66;
         end
         4'd11: begin
            opa = smag_ff[32:0]; opb = smag_ff[32:0];
         end
         4'd12: begin
            opa = smag_ff[65:33]; opb = smag_ff[32:0]; osh = SH34;
         end
         4'd13: begin
            opa = smag_ff[65:33]; opb = smag_ff[65:33]; osh = SH66;
         end
         default: begin
            opa = '0;
         end
      endcase
   end

   assign prod_ext = AccW'(prod_ff);

   always_comb begin
      case (psh_ff)
         SH0:     shifted = prod_ext;
         SH16:    shifted = prod_ext << 16;
         SH33:    shifted = prod_ext << 33;
         SH34:    shifted = prod_ext << 34;
         SH66:    shifted = prod_ext << 66;
         default: shifted = prod_ext;
      endcase
   end

   assign term    = pneg_ff ? (~shifted + 1'b1) : shifted;
   assign dext    = {{(AccW - CompW - 16){plane.d[CompW-1]}}, plane.d, 16'h0000};
   assign acc_abs = acc_ff[AccW-1] ? (~acc_ff + 1'b1) : acc_ff;

   always_comb begin
      if (step_ff == 4'd0) begin
         acc_in = dext + term;
      end else if (step_ff == 4'd3 && req_ff.norm && !req_ff.is_box) begin
         acc_in = term;
      end else if (step_ff == 4'd6) begin
         acc_in = '0;
      end else begin
         acc_in = acc_ff + term;
      end
   end

   assign acc_neg  = acc_ff[AccW-1];
   assign acc_zero = (acc_ff == '0);

   always_comb begin
      if (req_ff.is_box) begin
         outside = acc_neg || acc_zero;
      end else if (!req_ff.norm) begin
         outside = acc_neg;
      end else if (!req_ff.rad[31]) begin
         outside = sneg_ff && !acc_neg && !acc_zero;
      end else begin
         outside = sneg_ff || acc_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         plane_ff  <= '0;
         inside_ff <= 1'b1;
         result_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start_test) begin
                  state_ff  <= ST_MUL;
                  step_ff   <= '0;
                  plane_ff  <= '0;
                  inside_ff <= 1'b1;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (step_ff == last_step) begin
                  state_ff <= ST_DECIDE;
               end else begin
                  step_ff  <= step_ff + 4'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DECIDE: begin
               inside_ff <= inside_ff & ~outside;
               step_ff   <= '0;
               if (plane_ff == LastPlane) begin
                  state_ff  <= ST_IDLE;
                  plane_ff  <= '0;
                  result_ff <= inside_ff & ~outside;
               end else begin
                  plane_ff <= plane_ff + 3'd1;
                  state_ff <= ST_MUL;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == ST_DECIDE) && (plane_ff == LastPlane);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start_test) begin
         req_ff <= req;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= {33'b0, opa} * {33'b0, opb};
         pneg_ff <= oneg;
         psh_ff  <= osh;
         if (step_ff == 4'd3) begin
            smag_ff <= acc_abs[ProdW-1:0];
            sneg_ff <= acc_neg;
         end
         if (step_ff == 4'd6) begin
            nn_ff <= acc_ff[ProdW-1:0];
         end
      end
      if (state_ff == ST_ACC) begin
         acc_ff <= acc_in;
         if (step_ff == 4'd6) begin
            r2_ff <= prod_ff[62:0];
         end
      end
   end

   assign stat.busy    = (state_ff != ST_IDLE);
   assign stat.advance = (state_ff == ST_DECIDE);
   assign stat.done    = done_ff;
   assign stat.in_view = result_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == ST_IDLE && plane_ff == 3'd0))
      else $error("result issued while evaluator still active");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start_test) |=> (state_ff == ST_MUL && step_ff == 4'd0))
      else $error("test did not start at first step");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("two results for one test");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (step_ff <= last_step))
      else $error("step counter ran past last step");

endmodule
